FILE: rtl/core/sdlp_pkg.sv
// Shared types and constants for the SPI device line parser.
// No dependencies.
package sdlp_pkg;

	typedef enum logic [2:0] {
		PH_PROTO = 3'd0,
		PH_NAME  = 3'd1,
		PH_SLAVE = 3'd2,
		PH_START = 3'd3,
		PH_TAIL  = 3'd4,
		PH_ERROR = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_PROTO = 2'd1,
		ST_SLAVE = 2'd2,
		ST_START = 2'd3
	} status_t;

	typedef enum logic {
		KIND_NAME    = 1'b0,
		KIND_SUMMARY = 1'b1
	} kind_t;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_S     = 8'h53;
	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_I     = 8'h49;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF_HEX = 8'h66;
	localparam logic [7:0] CASE_BIT = 8'h20;

	localparam logic [5:0] CAP_RESET = 6'd32;

	function automatic logic is_dec(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		logic [7:0] l;
		l = c | CASE_BIT;
		return is_dec(c) || ((l >= CH_LA) && (l <= CH_LF_HEX));
	endfunction

	function automatic logic [3:0] hex_value(input logic [7:0] c);
		logic [7:0] v;
		if (c > CH_NINE) begin
			v = (c | CASE_BIT) - CH_LA + 8'd10;
		end else begin
			v = c - CH_ZERO;
		end
		return v[3:0];
	endfunction

endpackage

FILE: rtl/core/spi_device_line_parser.sv
// Top level of the SPI device line parser: input register, line state, result register.
// Depends on sdlp_pkg.
//
// Parses lines of the form SPIn,name,hh,ddd, one character per transaction on the
// input channel; a zero byte ends the line. Each accepted name character gives a
// name result; the zero byte gives a summary with port index, slave address,
// start address, name length and the first error latched during the line, or the
// error of a field that the zero byte cuts short. The block takes one character
// every cycle while the input does not stall: each character is decoded in a single
// pass from the input register against the line state, and its result goes to an
// output register. Back-pressure on the output holds the input register, and the
// input stalls only while both are full. name_capacity is written through
// cfg_wr_en/cfg_wr_data; the user must write it only while the block is idle, which
// the block itself does not enforce; names are limited to the smaller of it and NAME_MAX.
module spi_device_line_parser
	import sdlp_pkg::*;
#(
	parameter int NAME_MAX = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] char_in,
	input  logic       cfg_wr_en,
	input  logic [5:0] cfg_wr_data,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       result_kind,
	output logic [7:0] name_char,
	output logic [5:0] name_length,
	output logic [3:0] port_index,
	output logic [7:0] slave_address,
	output logic [9:0] start_address,
	output logic [1:0] status
);

	localparam logic [7:0] NameMaxW = 8'(NAME_MAX);

	// configuration
	logic [5:0] cap_q;

	// input stage
	logic       valid_s1;
	logic [7:0] char_s1;

	// line state
	phase_t     phase_q, phase_d;
	logic [2:0] fcount_q, fcount_d;
	logic [5:0] ncount_q, ncount_d;
	logic [3:0] port_q, port_d;
	logic [7:0] addr_q, addr_d;
	logic [9:0] dec_q, dec_d;
	status_t    err_q, err_d;

	// result register
	logic       out_valid_q;
	kind_t      kind_q, kind_d;
	logic [7:0] nchar_q, nchar_d;
	logic [5:0] nlen_q, nlen_d;
	logic [3:0] port_out_q, port_out_d;
	logic [7:0] addr_out_q, addr_out_d;
	logic [9:0] dec_out_q, dec_out_d;
	status_t    stat_q, stat_d;
	logic       emit;

	logic       advance;
	logic [7:0] limit;
	logic [7:0] c;
	logic [9:0] dec_times10;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign c        = char_s1;
	assign limit    = ({2'b00, cap_q} < NameMaxW) ? {2'b00, cap_q} : NameMaxW;
	assign dec_times10 = (dec_q << 3) + (dec_q << 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_wr_en) begin
			cap_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1 <= char_in;
		end
	end

	always_comb begin
		phase_d    = phase_q;
		fcount_d   = fcount_q;
		ncount_d   = ncount_q;
		port_d     = port_q;
		addr_d     = addr_q;
		dec_d      = dec_q;
		err_d      = err_q;
		emit       = 1'b0;
		kind_d     = KIND_NAME;
		nchar_d    = c;
		nlen_d     = ncount_q;
		port_out_d = port_q;
		addr_out_d = addr_q;
		dec_out_d  = dec_q;
		stat_d     = ST_OK;

		if (c == CH_NUL) begin
			// end of line: a cut-short field gives its own error
			stat_d = err_q;
			case (phase_q)
				PH_PROTO: stat_d = ST_PROTO;
				PH_NAME,
				PH_SLAVE: stat_d = ST_SLAVE;
				PH_START: begin
					if (fcount_q == 3'd0) begin
						stat_d = ST_START;
					end
				end
				default: ;
			endcase
			emit     = 1'b1;
			kind_d   = KIND_SUMMARY;
			nchar_d  = CH_NUL;
			phase_d  = PH_PROTO;
			fcount_d = '0;
			ncount_d = '0;
			port_d   = '0;
			addr_d   = '0;
			dec_d    = '0;
			err_d    = ST_OK;
		end else begin
			case (phase_q)
				PH_PROTO: begin
					if (c == CH_COMMA) begin
						if (fcount_q == 3'd4) begin
							phase_d  = PH_NAME;
							fcount_d = '0;
						end else begin
							phase_d = PH_ERROR;
							err_d   = ST_PROTO;
						end
					end else if (fcount_q == 3'd0 && c == CH_S) begin
						fcount_d = 3'd1;
					end else if (fcount_q == 3'd1 && c == CH_P) begin
						fcount_d = 3'd2;
					end else if (fcount_q == 3'd2 && c == CH_I) begin
						fcount_d = 3'd3;
					end else if (fcount_q == 3'd3 && is_dec(c)) begin
						port_d   = 4'(c - CH_ZERO);
						fcount_d = 3'd4;
					end else begin
						phase_d = PH_ERROR;
						err_d   = ST_PROTO;
					end
				end
				PH_NAME: begin
					if (c == CH_COMMA) begin
						phase_d  = PH_SLAVE;
						fcount_d = '0;
					end else if ({2'b00, ncount_q} >= limit) begin
						phase_d = PH_ERROR;
						err_d   = ST_SLAVE;
					end else begin
						ncount_d = ncount_q + 6'd1;
						nlen_d   = ncount_q + 6'd1;
						emit     = 1'b1;
					end
				end
				PH_SLAVE: begin
					if (c == CH_COMMA) begin
						if (fcount_q == 3'd0) begin
							phase_d = PH_ERROR;
							err_d   = ST_SLAVE;
						end else begin
							phase_d  = PH_START;
							fcount_d = '0;
						end
					end else if (is_hex(c) && fcount_q < 3'd2) begin
						addr_d   = {addr_q[3:0], hex_value(c)};
						fcount_d = fcount_q + 3'd1;
					end else begin
						phase_d = PH_ERROR;
						err_d   = ST_SLAVE;
					end
				end
				PH_START: begin
					if (is_dec(c)) begin
						dec_d    = dec_times10 + 10'(c - CH_ZERO);
						fcount_d = fcount_q + 3'd1;
						if (fcount_q >= 3'd2) begin
							phase_d = PH_TAIL;
						end
					end else if ((c == CH_LF || c == CH_SPACE) && fcount_q != 3'd0) begin
						phase_d = PH_TAIL;
					end else begin
						phase_d = PH_ERROR;
						err_d   = ST_START;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_PROTO;
			fcount_q <= '0;
			ncount_q <= '0;
			port_q   <= '0;
			addr_q   <= '0;
			dec_q    <= '0;
			err_q    <= ST_OK;
		end else if (advance) begin
			phase_q  <= phase_d;
			fcount_q <= fcount_d;
			ncount_q <= ncount_d;
			port_q   <= port_d;
			addr_q   <= addr_d;
			dec_q    <= dec_d;
			err_q    <= err_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			kind_q     <= kind_d;
			nchar_q    <= nchar_d;
			nlen_q     <= nlen_d;
			port_out_q <= port_out_d;
			addr_out_q <= addr_out_d;
			dec_out_q  <= dec_out_d;
			stat_q     <= stat_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign result_kind   = kind_q;
	assign name_char     = nchar_q;
	assign name_length   = nlen_q;
	assign port_index    = port_out_q;
	assign slave_address = addr_out_q;
	assign start_address = dec_out_q;
	assign status        = stat_q;

	// name results never carry an error
	a_name_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == KIND_NAME |-> status == ST_OK)
		else $error("name transaction with nonzero status");

	// a name result never goes past the configured limit
	a_name_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == KIND_NAME |-> name_length <= cap_q
			&& {2'b00, name_length} <= NameMaxW)
		else $error("name length beyond limit");

	// a zero byte always returns the line state to its start
	a_line_clear: assert property (@(posedge clk) disable iff (!arst_n)
		advance && char_s1 == CH_NUL |=> phase_q == PH_PROTO && ncount_q == '0
			&& err_q == ST_OK && out_valid_q && kind_q == KIND_SUMMARY)
		else $error("line state not cleared after end of line");

	// error phase always holds a latched error code
	a_err_latched: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_ERROR |-> err_q != ST_OK)
		else $error("error phase without error code");

	// input stalls only when both registers are full and the output is blocked
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && out_valid_q && !out_ready)
		else $error("input stalled without cause");

endmodule
